@@ hdl/asp_pkg.sv @@
package asp_pkg;

   // request function codes
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_RENDER = 2'd2;

   // address scrambling masks
   localparam logic [12:0] BMP_KEEP_MASK = 13'h181F;
   localparam logic [12:0] BMP_LINE_MASK = 13'h0700;
   localparam logic [12:0] BMP_ROW_MASK  = 13'h00E0;
   localparam logic [12:0] ATT_BASE      = 13'h1800;
   localparam logic [12:0] ATT_COL_MASK  = 13'h001F;
   localparam logic [12:0] ATT_ROW_MASK  = 13'h1F00;

   // colour levels
   localparam logic [7:0] LEVEL_NORMAL = 8'hCC;
   localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;

   // attribute bit positions
   localparam int unsigned ATTR_BRIGHT_BIT = 6;
   localparam int unsigned ATTR_FLASH_BIT  = 7;
   localparam int unsigned FRAME_FLASH_BIT = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_BMP,
      ST_RD_ATT,
      ST_CALC
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic wr_en;
      logic tick;
      logic cap_req;
      logic rd_en;
      logic rd_att;
      logic cap_bits;
      logic load_rsp;
   } cmd_type;

   // colour index to packed rgb: bit 0 blue, bit 1 red, bit 2 green
   function automatic logic [23:0] index_to_rgb(input logic [2:0] idx, input logic bright);
      logic [7:0]  level;
      logic [23:0] rgb;
      level = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
      rgb   = '0;
      if (idx[0]) rgb[7:0]   = level;
      if (idx[1]) rgb[23:16] = level;
      if (idx[2]) rgb[15:8]  = level;
      return rgb;
   endfunction

endpackage

@@ hdl/asp_ctrl.sv @@
module asp_ctrl
   import asp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_RENDER) state_in = ST_RD_BMP;
         end
         ST_RD_BMP: state_in = ST_RD_ATT;
         ST_RD_ATT: state_in = ST_CALC;
         ST_CALC: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.wr_en   = accept && req_func == FUNC_WRITE;
            cmd.tick    = accept && req_func == FUNC_TICK;
            cmd.cap_req = accept && req_func == FUNC_RENDER;
         end
         ST_RD_BMP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_att = 1'b0;
         end
         ST_RD_ATT: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_att   = 1'b1;
            cmd.cap_bits = 1'b1;
         end
         ST_CALC: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/asp_datapath.sv @@
module asp_datapath
   import asp_pkg::*;
#(
   parameter int unsigned VIDEO_BYTES = 8192
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [12:0] req_write_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   output logic [23:0] rsp_colour_rgb
);

   localparam int unsigned AW = $clog2(VIDEO_BYTES);
   localparam logic [14:0] DEPTH = 15'(VIDEO_BYTES);

   logic [7:0]    mem [VIDEO_BYTES];

   logic [7:0]    x_ff, y_ff;
   logic [4:0]    frame_ff;
   logic [7:0]    rd_data_ff;
   logic          rd_ok_ff;
   logic          on_ff;
   logic [23:0]   colour_ff;

   logic [12:0]   p;
   logic [12:0]   bmp_addr;
   logic [12:0]   att_addr;
   logic [12:0]   rd_addr;
   logic          rd_in_range;
   logic          wr_in_range;
   logic [7:0]    attr;
   logic [2:0]    ink, paper, idx;

   // screen address scrambling
   assign p        = {y_ff, x_ff[7:3]};
   assign bmp_addr = (p & BMP_KEEP_MASK) | ((p & BMP_LINE_MASK) >> 3)
                   | ((p & BMP_ROW_MASK) << 3);
   assign att_addr = ATT_BASE | (p & ATT_COL_MASK) | ((p & ATT_ROW_MASK) >> 3);
   assign rd_addr  = cmd.rd_att ? att_addr : bmp_addr;

   assign rd_in_range = {2'b00, rd_addr} < DEPTH;
   assign wr_in_range = {2'b00, req_write_address} < DEPTH;

   // video memory, one access per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_in_range) begin
         mem[AW'(req_write_address)] <= req_write_data;
      end
      if (cmd.rd_en && rd_in_range) begin
         rd_data_ff <= mem[AW'(rd_addr)];
      end
      if (cmd.rd_en) begin
         rd_ok_ff <= rd_in_range;
      end
   end

   // pixel position capture and bitmap bit pick
   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         x_ff <= req_pixel_x;
         y_ff <= req_pixel_y;
      end
      if (cmd.cap_bits) begin
         on_ff <= rd_ok_ff && rd_data_ff[3'd7 - x_ff[2:0]];
      end
   end

   // frame counter for flash
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (cmd.tick) begin
         frame_ff <= frame_ff + 5'd1;
      end
   end

   // attribute decode with flash swap
   always_comb begin
      attr  = rd_ok_ff ? rd_data_ff : 8'h00;
      ink   = attr[2:0];
      paper = attr[5:3];
      if (attr[ATTR_FLASH_BIT] && frame_ff[FRAME_FLASH_BIT]) begin
         ink   = attr[5:3];
         paper = attr[2:0];
      end
      idx = on_ff ? ink : paper;
   end

   // output colour register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         colour_ff <= index_to_rgb(idx, attr[ATTR_BRIGHT_BIT]);
      end
   end

   assign rsp_colour_rgb = colour_ff;

endmodule

@@ hdl/attribute_screen_pixel_renderer.sv @@
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// req      | in        | req_valid/req_ready  | func, write_address, write_data, x, y
// rsp      | out       | rsp_valid/rsp_ready  | colour_rgb
//
// Write, frame tick and unused requests finish in the idle state that takes them.
// A render request leaves idle, and in turn the single memory port reads the
// bitmap byte, then the attribute byte, then the colour is formed.
// Reset clears the frame counter and control; video memory is undefined until written.
// A waiting response is held in its register; requests are still taken
// meanwhile, and a render stalls only in its last step until the output frees up.
module attribute_screen_pixel_renderer
   import asp_pkg::*;
#(
   parameter int unsigned VIDEO_BYTES = 8192
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [12:0] req_write_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_colour_rgb
);

   cmd_type cmd;

   // sequencing
   asp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // memory, addressing and colour
   asp_datapath #(
      .VIDEO_BYTES (VIDEO_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_write_address (req_write_address),
      .req_write_data    (req_write_data),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_colour_rgb    (rsp_colour_rgb)
   );

endmodule

@@ sim/asp_screen_map_pkg.sv @@
package asp_screen_map_pkg;

   import asp_pkg::*;

   localparam int unsigned SCREEN_BYTES = 8192;

   // function code that the block takes and drops
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // one request as offered on the input channel
   typedef struct packed {
      logic [1:0]  func;
      logic [12:0] write_address;
      logic [7:0]  write_data;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
   } screen_req_type;

   // linear character cell index: line times 32 plus column byte
   function automatic logic [12:0] pixel_cell(input logic [7:0] x, input logic [7:0] y);
      return {y, x[7:3]};
   endfunction

   // interleaved bitmap byte for a cell
   function automatic logic [12:0] bitmap_addr(input logic [12:0] pos);
      return (pos & BMP_KEEP_MASK) | ((pos & BMP_LINE_MASK) >> 3)
           | ((pos & BMP_ROW_MASK) << 3);
   endfunction

   // attribute byte for a cell
   function automatic logic [12:0] attr_addr(input logic [12:0] pos);
      return ATT_BASE | (pos & ATT_COL_MASK) | ((pos & ATT_ROW_MASK) >> 3);
   endfunction

endpackage

@@ sim/asp_checker.sv @@
module asp_checker
   import asp_pkg::*;
   import asp_screen_map_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [12:0] req_write_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [23:0] rsp_colour_rgb,
   output int unsigned fail_count,
   output int unsigned pending
);

   logic [7:0]  vram_copy [SCREEN_BYTES];
   logic [4:0]  frame_ctr;
   logic [23:0] colour_expect_q [$];
   int unsigned mismatches = 0;
   int unsigned waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // read a byte of the shadow memory, zero beyond its end
   function automatic logic [7:0] vram_byte(input logic [12:0] addr);
      if (addr >= SCREEN_BYTES) return 8'h00;
      return vram_copy[addr];
   endfunction

   // colour the block should give for one pixel
   function automatic logic [23:0] pixel_colour(input logic [7:0] x, input logic [7:0] y);
      logic [12:0] pos;
      logic [7:0]  bits;
      logic [7:0]  attr;
      logic [2:0]  ink;
      logic [2:0]  paper;
      logic [2:0]  idx;
      logic [7:0]  lvl;
      pos   = pixel_cell(x, y);
      bits  = vram_byte(bitmap_addr(pos));
      attr  = vram_byte(attr_addr(pos));
      ink   = attr[2:0];
      paper = attr[5:3];
      // flashing cells swap ink and paper in the upper half of the frame cycle
      if (attr[ATTR_FLASH_BIT] && frame_ctr[FRAME_FLASH_BIT]) begin
         ink   = attr[5:3];
         paper = attr[2:0];
      end
      idx = bits[3'd7 - x[2:0]] ? ink : paper;
      lvl = attr[ATTR_BRIGHT_BIT] ? LEVEL_BRIGHT : LEVEL_NORMAL;
      return {idx[1] ? lvl : 8'h00, idx[2] ? lvl : 8'h00, idx[0] ? lvl : 8'h00};
   endfunction

   // watch both channels, predict on requests, compare on responses
   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         frame_ctr = '0;
         colour_expect_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (colour_expect_q.size() == 0) begin
               $error("colour_rgb: no response expected, actual %06h", rsp_colour_rgb);
               mismatches++;
            end else begin
               want = colour_expect_q.pop_front();
               if (want !== rsp_colour_rgb) begin
                  $error("colour_rgb: expected %06h, actual %06h", want, rsp_colour_rgb);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_func)
               FUNC_WRITE: begin
                  if (req_write_address < SCREEN_BYTES)
                     vram_copy[req_write_address] = req_write_data;
               end
               FUNC_TICK: begin
                  frame_ctr = frame_ctr + 5'd1;
               end
               FUNC_RENDER: begin
                  colour_expect_q.push_back(pixel_colour(req_pixel_x, req_pixel_y));
               end
               default: begin
               end
            endcase
         end
      end
      waiting = colour_expect_q.size();
   end

endmodule

@@ sim/tb.sv @@
module tb;

   import asp_pkg::*;
   import asp_screen_map_pkg::*;

   localparam int unsigned HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [12:0] req_write_address = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_pixel_x = '0;
   logic [7:0]  req_pixel_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_colour_rgb;

   int unsigned fail_count;
   int unsigned pending;

   screen_req_type req_q [$];
   screen_req_type next_req;
   bit          byte_set [SCREEN_BYTES];
   int unsigned send_idle_pct = 38;
   int unsigned recv_idle_pct = 38;
   logic        hold_go = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   attribute_screen_pixel_renderer #(
      .VIDEO_BYTES(SCREEN_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_write_address (req_write_address),
      .req_write_data    (req_write_data),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_colour_rgb    (rsp_colour_rgb)
   );

   asp_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_write_address (req_write_address),
      .req_write_data    (req_write_data),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_colour_rgb    (rsp_colour_rgb),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // request driver: offer the next queued request, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req          = req_q.pop_front();
            req_valid         <= 1'b1;
            req_func          <= next_req.func;
            req_write_address <= next_req.write_address;
            req_write_data    <= next_req.write_data;
            req_pixel_x       <= next_req.pixel_x;
            req_pixel_y       <= next_req.pixel_y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_req(input logic [1:0] func, input logic [12:0] addr,
                           input logic [7:0] data, input logic [7:0] x, input logic [7:0] y);
      screen_req_type item;
      item.func          = func;
      item.write_address = addr;
      item.write_data    = data;
      item.pixel_x       = x;
      item.pixel_y       = y;
      if (func == FUNC_WRITE) byte_set[addr] = 1'b1;
      req_q.push_back(item);
   endtask

   // render request with junk in the unused fields; bytes it reads get written first
   task automatic push_render(input logic [7:0] x, input logic [7:0] y);
      logic [12:0] pos;
      pos = pixel_cell(x, y);
      if (!byte_set[bitmap_addr(pos)])
         push_req(FUNC_WRITE, bitmap_addr(pos), 8'($urandom), 8'($urandom), 8'($urandom));
      if (!byte_set[attr_addr(pos)])
         push_req(FUNC_WRITE, attr_addr(pos), 8'($urandom), 8'($urandom), 8'($urandom));
      push_req(FUNC_RENDER, 13'($urandom), 8'($urandom), x, y);
   endtask

   task automatic drain();
      while (req_q.size() != 0 || req_valid) @(negedge clock);
   endtask

   // mostly visible lines, some beyond the bitmap
   function automatic logic [7:0] random_line();
      if ($urandom_range(9) == 0) return 8'($urandom_range(255, 192));
      return 8'($urandom_range(191));
   endfunction

   // random traffic: aimed write-then-render sequences, plain renders,
   // stray writes, frame ticks and dropped function codes
   task automatic queue_random_mix(input int unsigned n);
      int unsigned made;
      int unsigned pick;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [12:0] pos;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         x    = 8'($urandom);
         y    = random_line();
         pos  = pixel_cell(x, y);
         if (pick < 40) begin
            if ($urandom_range(1) == 1) begin
               push_req(FUNC_WRITE, bitmap_addr(pos), 8'($urandom), 8'($urandom),
                        8'($urandom));
               made++;
            end
            if ($urandom_range(1) == 1) begin
               push_req(FUNC_WRITE, attr_addr(pos), 8'($urandom), 8'($urandom),
                        8'($urandom));
               made++;
            end
            if ($urandom_range(3) == 0) begin
               push_req(FUNC_TICK, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
               made++;
            end
            push_render(x, y);
            made++;
            // other pixel of the same byte
            if ($urandom_range(1) == 1) begin
               push_render(x ^ 8'd1, y);
               made++;
            end
         end else if (pick < 65) begin
            push_render(x, y);
            made++;
         end else if (pick < 80) begin
            if ($urandom_range(3) == 0)
               push_req(FUNC_WRITE, 13'($urandom_range(13'h1BFF, 13'h1800)), 8'($urandom),
                        8'($urandom), 8'($urandom));
            else
               push_req(FUNC_WRITE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            made++;
         end else if (pick < 93) begin
            push_req(FUNC_TICK, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            made++;
         end else begin
            push_req(FUNC_UNUSED, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: corner pixels, bright and flash, lines past the bitmap
      push_req(FUNC_WRITE, 13'h0000, 8'h80, 8'h00, 8'h00);
      push_req(FUNC_WRITE, ATT_BASE, 8'hC5, 8'hFF, 8'hFF);
      push_render(8'd0, 8'd0);
      push_render(8'd1, 8'd0);
      push_req(FUNC_WRITE, 13'h1FFF, 8'hFF, 8'h00, 8'h00);
      push_req(FUNC_WRITE, 13'h1BFF, 8'h3A, 8'h00, 8'h00);
      push_render(8'd255, 8'd255);
      push_render(8'd0, 8'd192);
      push_render(8'd255, 8'd191);
      push_req(FUNC_UNUSED, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
      // sixteen ticks put the flash phase into its swapped half
      repeat (16) push_req(FUNC_TICK, 13'h0000, 8'h00, 8'h00, 8'h00);
      push_render(8'd0, 8'd0);
      push_render(8'd1, 8'd0);
      push_req(FUNC_WRITE, ATT_BASE, 8'h40, 8'h00, 8'h00);
      push_render(8'd0, 8'd0);
      drain();

      // long stretch with no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_mix(250);
      drain();

      // receiver holds off while renders keep coming
      hold_go = 1'b1;
      repeat (40) push_render(8'($urandom), random_line());
      drain();

      send_idle_pct = 38;
      recv_idle_pct = 38;
      queue_random_mix(700);
      drain();

      while (pending != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS attribute_screen_pixel_renderer");
      end else begin
         $display("FAIL attribute_screen_pixel_renderer");
      end
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("FAIL attribute_screen_pixel_renderer");
      $finish;
   end

endmodule

@@ files.f @@
hdl/asp_pkg.sv
hdl/asp_ctrl.sv
hdl/asp_datapath.sv
hdl/attribute_screen_pixel_renderer.sv
sim/asp_screen_map_pkg.sv
sim/asp_checker.sv
sim/tb.sv
